### rtl/core/hufd_pkg.sv
// shared types and constants for the huffman tree byte decoder
`timescale 1ns / 1ps
`default_nettype none

package hufd_pkg;

   // node values: 0..255 leaf byte, 256..511 internal node
   localparam int NODE_W     = 9;
   localparam int BYTE_W     = 8;
   localparam int LEAF_MAX   = 'hFF;
   localparam int SIZE_W     = 32;
   localparam int CSR_IDX_W  = 1;

   // at most this many result words per data word
   localparam int RESULT_CAP = 32;
   localparam int RES_CNT_W  = 6;

   // fixed part of the request tdata: op, entry_index, entry_value
   localparam int OP_W       = 2;
   localparam int IN_FIXED_W = OP_W + NODE_W + NODE_W;

   // request op codes
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_DATA  = 2'd1;
   localparam logic [OP_W-1:0] OP_START = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_NODE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_SIZE = 1'd1;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // write one tree entry
      logic start;     // restart the stream
      logic word_go;   // latch a data word and clear per-word counters
      logic step;      // walk one bit
      logic flush;     // hand the held byte to the output with tlast
   } hufd_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic walk_done;   // no read pending and no bit, byte count or result room left for this word
      logic flush_done;  // held byte gone or leaving this cycle
   } hufd_sts_type;

   function automatic logic node_is_leaf(input logic [NODE_W-1:0] node);
      node_is_leaf = (node <= NODE_W'(LEAF_MAX));
   endfunction

endpackage

`default_nettype wire

### rtl/core/hufd_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module hufd_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/core/hufd_ctrl.sv
// controller state machine for the huffman tree byte decoder
`timescale 1ns / 1ps
`default_nettype none

module hufd_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [hufd_pkg::OP_W-1:0]   req_op,
   input  hufd_pkg::hufd_sts_type      sts,
   output hufd_pkg::hufd_cmd_type      cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_WALK  = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       req_acc;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               unique case (req_op)
                  hufd_pkg::OP_LOAD:  cmd.load = 1'b1;
                  hufd_pkg::OP_START: cmd.start = 1'b1;
                  hufd_pkg::OP_DATA: begin
                     cmd.word_go = 1'b1;
                     state_in    = S_WALK;
                  end
                  default: ;
               endcase
            end
         end
         S_WALK: begin
            cmd.step = 1'b1;
            if (sts.walk_done) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            if (sts.flush_done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/hufd_datapath.sv
// tree walk datapath, tree table, held byte and output register
`timescale 1ns / 1ps
`default_nettype none

module hufd_datapath #(
   parameter int WORD_BITS    = 32,
   parameter int TREE_ENTRIES = 512
) (
   input  logic                             clock,
   input  logic                             reset,
   input  hufd_pkg::hufd_cmd_type           cmd,
   output hufd_pkg::hufd_sts_type           sts,
   input  logic [hufd_pkg::NODE_W-1:0]      entry_index,
   input  logic [hufd_pkg::NODE_W-1:0]      entry_value,
   input  logic [WORD_BITS-1:0]             data_word,
   input  logic                             csr_we,
   input  logic [hufd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hufd_pkg::SIZE_W-1:0]      csr_wdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [hufd_pkg::BYTE_W-1:0]      out_byte,
   output logic                             last_of_run,
   output logic                             finished
);

   localparam int NW = hufd_pkg::NODE_W;
   localparam int AW = $clog2(TREE_ENTRIES);
   localparam int IW = $clog2(WORD_BITS + 1);
   localparam int CW = hufd_pkg::RES_CNT_W;
   localparam int SW = hufd_pkg::SIZE_W;
   localparam int BW = hufd_pkg::BYTE_W;

   // registers
   logic [NW-1:0]        root_ff;
   logic [SW-1:0]        size_ff;
   logic [NW-1:0]        node_ff, node_in;
   logic [SW-1:0]        bytes_left_ff, bytes_left_in;
   logic                 pend_ff, pend_in;
   logic                 oob_ff;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [IW-1:0]        bit_cnt_ff, bit_cnt_in;
   logic [CW-1:0]        res_cnt_ff, res_cnt_in;
   logic                 hold_v_ff, hold_v_in;
   logic [BW-1:0]        hold_byte_ff;
   logic                 hold_fin_ff;
   logic                 out_v_ff, out_v_in;
   logic [BW-1:0]        out_byte_ff;
   logic                 out_last_ff;
   logic                 out_fin_ff;

   // walk logic
   logic [NW-1:0]   rd_data;
   logic [NW-1:0]   post;
   logic [NW-1:0]   w;
   logic            a_emit;
   logic            b_emit;
   logic            b_read;
   logic            can_b;
   logic            emit;
   logic [BW-1:0]   emit_byte;
   logic            emit_fin;
   logic            bl_zero_a;
   logic [CW-1:0]   res_a;
   logic            stall;
   logic            adv;
   logic            out_free;
   logic            push_step;
   logic            push_flush;
   logic [NW-1:0]   rd_addr_full;
   logic            rd_en;
   logic            wr_en;

   // node reached by the previous bit's table read, out of range reads give node 0
   assign post      = oob_ff ? '0 : rd_data;
   assign a_emit    = pend_ff && hufd_pkg::node_is_leaf(post);
   assign w         = pend_ff ? (a_emit ? root_ff : post) : node_ff;
   assign bl_zero_a = a_emit ? (bytes_left_ff == SW'(1)) : (bytes_left_ff == '0);
   assign res_a     = res_cnt_ff + CW'(a_emit);

   // start the next bit unless the word, counter or result cap is used up;
   // a resolved leaf followed by a leaf root holds the next bit back (at most one byte per cycle)
   assign can_b = (bit_cnt_ff != IW'(WORD_BITS)) && !bl_zero_a
                  && (res_a != CW'(hufd_pkg::RESULT_CAP))
                  && !(a_emit && hufd_pkg::node_is_leaf(w));
   assign b_read = can_b && !hufd_pkg::node_is_leaf(w);
   assign b_emit = can_b && hufd_pkg::node_is_leaf(w);

   assign emit      = a_emit || b_emit;
   assign emit_byte = a_emit ? post[BW-1:0] : w[BW-1:0];
   assign emit_fin  = (bytes_left_ff == SW'(1));

   assign out_free   = !out_v_ff || rsp_tready;
   assign stall      = cmd.step && emit && hold_v_ff && !out_free;
   assign adv        = cmd.step && !stall;
   assign push_step  = adv && emit && hold_v_ff;
   assign push_flush = cmd.flush && hold_v_ff && out_free;

   assign sts.walk_done  = !pend_ff && ((bit_cnt_ff == IW'(WORD_BITS))
                           || (bytes_left_ff == '0)
                           || (res_cnt_ff == CW'(hufd_pkg::RESULT_CAP)));
   assign sts.flush_done = !hold_v_ff || out_free;

   // child entry of internal node n on bit b is (n - 256) * 2 + b
   assign rd_addr_full = {w[BW-1:0], word_ff[0]};
   assign rd_en        = adv && b_read;
   assign wr_en        = cmd.load && ({1'b0, entry_index} < (NW+1)'(TREE_ENTRIES));

   hufd_ram #(
      .WIDTH(NW),
      .DEPTH(TREE_ENTRIES)
   ) u_tree_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(entry_index[AW-1:0]),
      .wr_data(entry_value),
      .rd_en  (rd_en),
      .rd_addr(rd_addr_full[AW-1:0]),
      .rd_data(rd_data)
   );

   always_comb begin
      node_in       = node_ff;
      pend_in       = pend_ff;
      bytes_left_in = bytes_left_ff;
      word_in       = word_ff;
      bit_cnt_in    = bit_cnt_ff;
      res_cnt_in    = res_cnt_ff;
      hold_v_in     = hold_v_ff;
      out_v_in      = out_v_ff;
      if (cmd.start) begin
         node_in       = root_ff;
         pend_in       = 1'b0;
         bytes_left_in = size_ff;
      end
      if (cmd.word_go) begin
         word_in    = data_word;
         bit_cnt_in = '0;
         res_cnt_in = '0;
      end
      if (adv) begin
         node_in = b_emit ? root_ff : w;
         pend_in = b_read;
         if (emit) begin
            bytes_left_in = bytes_left_ff - SW'(1);
            res_cnt_in    = res_cnt_ff + CW'(1);
            hold_v_in     = 1'b1;
         end
         if (can_b) begin
            word_in    = word_ff >> 1;
            bit_cnt_in = bit_cnt_ff + IW'(1);
         end
      end
      if (push_flush) begin
         hold_v_in = 1'b0;
      end
      if (push_step || push_flush) begin
         out_v_in = 1'b1;
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff       <= '0;
         size_ff       <= '0;
         node_ff       <= '0;
         pend_ff       <= 1'b0;
         bytes_left_ff <= '0;
         bit_cnt_ff    <= '0;
         res_cnt_ff    <= '0;
         hold_v_ff     <= 1'b0;
         out_v_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               hufd_pkg::CSR_ROOT_NODE:   root_ff <= csr_wdata[NW-1:0];
               hufd_pkg::CSR_OUTPUT_SIZE: size_ff <= csr_wdata;
               default: ;
            endcase
         end
         node_ff       <= node_in;
         pend_ff       <= pend_in;
         bytes_left_ff <= bytes_left_in;
         bit_cnt_ff    <= bit_cnt_in;
         res_cnt_ff    <= res_cnt_in;
         hold_v_ff     <= hold_v_in;
         out_v_ff      <= out_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (rd_en) begin
         oob_ff <= ({1'b0, rd_addr_full} >= (NW+1)'(TREE_ENTRIES));
      end
      if (adv && emit) begin
         hold_byte_ff <= emit_byte;
         hold_fin_ff  <= emit_fin;
      end
      if (push_step || push_flush) begin
         out_byte_ff <= hold_byte_ff;
         out_fin_ff  <= hold_fin_ff;
         out_last_ff <= push_flush;
      end
   end

   assign rsp_tvalid  = out_v_ff;
   assign out_byte    = out_byte_ff;
   assign last_of_run = out_last_ff;
   assign finished    = out_fin_ff;

`ifndef SYNTH
   a_bytes_left_only_drops : assert property (@(posedge clock) disable iff (reset)
      !cmd.start |=> bytes_left_ff <= $past(bytes_left_ff))
      else $error("byte counter rose without a start");

   a_stall_freezes_walk : assert property (@(posedge clock) disable iff (reset)
      stall |=> $stable(node_ff) && $stable(pend_ff) && $stable(bit_cnt_ff))
      else $error("walk advanced during an output stall");

   a_final_byte_ends_walk : assert property (@(posedge clock) disable iff (reset)
      (adv && emit && emit_fin) |=> sts.walk_done)
      else $error("walk continued after the last byte of the stream");
`endif

endmodule

`default_nettype wire

### rtl/core/huffman_tree_byte_decoder_unit.sv
// top level of the huffman tree byte decoder
//
// channel | dir | handshake             | content
// --------+-----+-----------------------+------------------------------------------
// req     | in  | req_tvalid/req_tready | op, entry_index, entry_value, data_word
// rsp     | out | rsp_tvalid/rsp_tready | out_byte, tlast = last_of_run, tuser = finished
// csr     | in  | csr_we                | root node (index 0), output_size (index 1)
//
// load, start and unused op words are taken while idle and do not leave it
// a data word holds req_tready low through its walk and flush: at most one table ram read
// per bit, then resolving the last read, seeing the walk end and handing over the held byte;
// the next word is taken only after that flush, and the walk ends early when the count ends
// a resolved leaf followed by a leaf root holds the next bit back
// output stalls freeze the walk; the next word is taken while a byte still waits on rsp
// reset is synchronous; tree table contents are not cleared and need no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module huffman_tree_byte_decoder_unit #(
   parameter int WORD_BITS    = 32,
   parameter int TREE_ENTRIES = 512
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // req word
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // tdata from bit 0: op, entry_index, entry_value, data_word, zero pad
   input  logic [((hufd_pkg::IN_FIXED_W + WORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // rsp word
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [hufd_pkg::BYTE_W-1:0]            rsp_tdata,  // out_byte
   output logic                                   rsp_tlast,  // last_of_run
   output logic                                   rsp_tuser,  // finished
   // configuration writes
   input  logic                                   csr_we,
   input  logic [hufd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [hufd_pkg::SIZE_W-1:0]            csr_wdata
);

   localparam int OP_LO  = 0;
   localparam int IDX_LO = hufd_pkg::OP_W;
   localparam int VAL_LO = IDX_LO + hufd_pkg::NODE_W;
   localparam int WRD_LO = VAL_LO + hufd_pkg::NODE_W;

   // unpacked request fields
   logic [hufd_pkg::OP_W-1:0]   req_op;
   logic [hufd_pkg::NODE_W-1:0] req_entry_index;
   logic [hufd_pkg::NODE_W-1:0] req_entry_value;
   logic [WORD_BITS-1:0]        req_data_word;

   hufd_pkg::hufd_cmd_type cmd;
   hufd_pkg::hufd_sts_type sts;

   assign req_op          = req_tdata[OP_LO +: hufd_pkg::OP_W];
   assign req_entry_index = req_tdata[IDX_LO +: hufd_pkg::NODE_W];
   assign req_entry_value = req_tdata[VAL_LO +: hufd_pkg::NODE_W];
   assign req_data_word   = req_tdata[WRD_LO +: WORD_BITS];

   // controller: accepts words while idle, sequences walk and flush
   hufd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_op    (req_op),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: tree ram, walk registers, held byte for tlast lookahead, output register
   hufd_datapath #(
      .WORD_BITS   (WORD_BITS),
      .TREE_ENTRIES(TREE_ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .entry_index(req_entry_index),
      .entry_value(req_entry_value),
      .data_word  (req_data_word),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_byte   (rsp_tdata),
      .last_of_run(rsp_tlast),
      .finished   (rsp_tuser)
   );

endmodule

`default_nettype wire

### bench/huffman_tree_byte_decoder_unit_test.sv
// self-checking testbench for the huffman tree byte decoder unit
`timescale 1ns / 1ps

module huffman_tree_byte_decoder_unit_test;

   localparam int NODE_W        = hufd_pkg::NODE_W;
   localparam int BYTE_W        = hufd_pkg::BYTE_W;
   localparam int SIZE_W        = hufd_pkg::SIZE_W;
   localparam int OP_W          = hufd_pkg::OP_W;
   localparam int CSR_IDX_W     = hufd_pkg::CSR_IDX_W;
   localparam int LEAF_MAX      = hufd_pkg::LEAF_MAX;
   localparam int WORD_BITS     = 32;
   localparam int TREE_ENTRIES  = 512;
   localparam int REQ_W         = ((hufd_pkg::IN_FIXED_W + WORD_BITS + 7) / 8) * 8;
   localparam int PAD_W         = REQ_W - hufd_pkg::IN_FIXED_W - WORD_BITS;
   localparam int RANDOM_ITEMS  = 180;
   localparam int SETTLE_CYCLES = 100;   // covers a full word walk plus flush
   localparam int REPORT_MAX    = 10;

   // op code the block has no use for
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   // one decoded byte as it leaves the rsp channel
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              run_end;    // tlast, final byte of this data word
      logic              finished;   // tuser, byte count reached
   } decoded_byte_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [BYTE_W-1:0]  rsp_tdata;
   logic               rsp_tlast;
   logic               rsp_tuser;
   logic               csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SIZE_W-1:0]  csr_wdata  = '0;

   huffman_tree_byte_decoder_unit #(
      .WORD_BITS    (WORD_BITS),
      .TREE_ENTRIES (TREE_ENTRIES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------
   // decoder shadow state, updated as each word is accepted
   // ---------------------------------------------------------------
   logic [NODE_W-1:0] tree_mem [0:TREE_ENTRIES-1];
   bit                entry_set [0:TREE_ENTRIES-1];
   logic [NODE_W-1:0] walk_at    = '0;
   logic [SIZE_W-1:0] left_count = '0;
   logic [NODE_W-1:0] root_reg   = '0;
   logic [SIZE_W-1:0] size_reg   = '0;

   decoded_byte_type expected_bytes [$];

   int  errors      = 0;
   int  coded_items = 0;
   bit  quiet       = 1'b0;   // no idling on either side in the closing stretch
   int  send_calm   = 0;
   int  rsp_hold    = 0;
   int  rsp_calm    = 0;

   // a node may be handed out only if a walk from it never reads an unwritten entry
   function automatic bit node_ready(input logic [NODE_W-1:0] node);
      node_ready = (node <= LEAF_MAX) ||
                   (entry_set[{node[7:0], 1'b0}] && entry_set[{node[7:0], 1'b1}]);
   endfunction

   // work out the bytes one accepted request word produces
   task automatic decode_item(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] idx,
                              input logic [NODE_W-1:0] val, input logic [WORD_BITS-1:0] word);
      decoded_byte_type held;
      bit               have_held;
      held      = '0;
      have_held = 1'b0;
      case (op)
         hufd_pkg::OP_LOAD: begin
            tree_mem[idx]  = val;
            entry_set[idx] = 1'b1;
         end
         hufd_pkg::OP_START: begin
            left_count = size_reg;
            walk_at    = root_reg;
         end
         hufd_pkg::OP_DATA: begin
            // lsb first; a leaf walk position emits without a table step
            for (int b = 0; b < WORD_BITS; b++) begin
               if (left_count != 0) begin
                  if (walk_at > LEAF_MAX)
                     walk_at = tree_mem[{walk_at[7:0], word[b]}];
                  if (walk_at <= LEAF_MAX) begin
                     if (have_held)
                        expected_bytes.push_back(held);
                     left_count = left_count - 1;
                     held = '{out_byte: walk_at[7:0], run_end: 1'b0,
                              finished: (left_count == 0)};
                     have_held = 1'b1;
                     walk_at = root_reg;
                  end
               end
            end
            // tlast marks the final byte of the word
            if (have_held) begin
               held.run_end = 1'b1;
               expected_bytes.push_back(held);
            end
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------
   // request side: one word per call, random bursts of idle before it
   // ---------------------------------------------------------------
   task automatic send_item(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] idx,
                            input logic [NODE_W-1:0] val, input logic [WORD_BITS-1:0] word);
      int gap;
      gap = 0;
      if (!quiet) begin
         if (send_calm > 0)
            send_calm--;
         else if ($urandom_range(0, 9) == 0)
            send_calm = $urandom_range(10, 40);
         else if ($urandom_range(0, 2) == 0)
            gap = $urandom_range(1, 6);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{PAD_W{1'b0}}, word, val, idx, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_item(op, idx, val, word);
   endtask

   // drop valid, let every expected byte drain, then let a silent walk finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both registers back to back; only called with the block idle
   task automatic program_regs(input logic [NODE_W-1:0] root, input logic [SIZE_W-1:0] size);
      csr_we    <= 1'b1;
      csr_index <= hufd_pkg::CSR_ROOT_NODE;
      csr_wdata <= SIZE_W'(root);
      @(posedge clock);
      root_reg   = root;
      csr_index <= hufd_pkg::CSR_OUTPUT_SIZE;
      csr_wdata <= size;
      @(posedge clock);
      size_reg  = size;
      csr_we   <= 1'b0;
   endtask

   // loads a small random tree bottom-up so no load points at an unfinished node
   task automatic build_tree(output logic [NODE_W-1:0] top);
      int                count;
      int                base;
      logic [NODE_W-1:0] child;
      count = $urandom_range(1, 12);
      base  = $urandom_range(256, 512 - count);
      for (int n = base + count - 1; n >= base; n--) begin
         for (int b = 0; b < 2; b++) begin
            if (n < base + count - 1 && $urandom_range(0, 9) < 4)
               child = NODE_W'($urandom_range(n + 1, base + count - 1));
            else
               child = NODE_W'($urandom_range(0, 255));
            send_item(hufd_pkg::OP_LOAD, {n[7:0], b[0]}, child, $urandom);
            coded_items++;
         end
      end
      top = NODE_W'(base);
   endtask

   // ---------------------------------------------------------------
   // result side: random stalls and calm stretches
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= rsp_hold - 1;
      end else if (rsp_calm > 0) begin
         rsp_tready <= 1'b1;
         rsp_calm   <= rsp_calm - 1;
      end else begin
         case ($urandom_range(0, 7))
            0: begin
               rsp_tready <= 1'b0;
               rsp_hold   <= $urandom_range(0, 5);
            end
            1: begin
               rsp_tready <= 1'b1;
               rsp_calm   <= $urandom_range(10, 50);
            end
            default: rsp_tready <= 1'b1;
         endcase
      end
   end

   // compare every accepted byte with the oldest expectation
   always @(posedge clock) begin
      decoded_byte_type got;
      decoded_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{out_byte: rsp_tdata, run_end: rsp_tlast, finished: rsp_tuser};
         if (expected_bytes.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("unexpected byte %02h last %0b fin %0b", got.out_byte,
                        got.run_end, got.finished);
         end else begin
            want = expected_bytes.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display("mismatch: expected byte %02h last %0b fin %0b, got %02h %0b %0b",
                           want.out_byte, want.run_end, want.finished,
                           got.out_byte, got.run_end, got.finished);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // directed tests
   // ---------------------------------------------------------------

   // counter is zero out of reset, so data words give nothing
   task automatic test_reset_state();
      send_item(hufd_pkg::OP_DATA, '0, '0, 32'hFFFF_FFFF);
      send_item(hufd_pkg::OP_DATA, '1, '1, 32'h0000_0000);
   endtask

   // two-node tree at the table extremes; node 511 bit 0 is leaf 0xff,
   // bit 1 goes to node 256 whose bit 0 is leaf 0 and bit 1 loops back
   task automatic test_tree_walk();
      send_item(hufd_pkg::OP_LOAD, 9'd510, 9'd255, 32'h0);
      send_item(hufd_pkg::OP_LOAD, 9'd511, 9'd256, 32'h0);
      send_item(hufd_pkg::OP_LOAD, 9'd0,   9'd0,   32'h0);
      send_item(hufd_pkg::OP_LOAD, 9'd1,   9'd511, 32'h0);
      wait_idle();
      program_regs(9'd511, 32'd5);
      send_item(hufd_pkg::OP_START, '0, '0, 32'h0);
      send_item(hufd_pkg::OP_DATA,  '0, '0, 32'h0000_0000);   // stops after five bytes
      send_item(hufd_pkg::OP_DATA,  '0, '0, 32'h0000_0000);   // counter exhausted
      send_item(hufd_pkg::OP_START, '0, '0, 32'h0);
      send_item(hufd_pkg::OP_DATA,  '0, '0, 32'hFFFF_FFFF);   // endless internal loop, no byte
      send_item(hufd_pkg::OP_DATA,  '0, '0, 32'hFFFF_FFFE);   // symbol left open at the top bit
      send_item(hufd_pkg::OP_DATA,  '0, '0, 32'h0000_0000);   // and closed by the next word
   endtask

   // zero, one and maximum byte counts
   task automatic test_size_extremes();
      wait_idle();
      program_regs(9'd511, 32'd0);
      send_item(hufd_pkg::OP_START, '0, '0, 32'h0);
      send_item(hufd_pkg::OP_DATA,  '0, '0, 32'h0000_0000);
      wait_idle();
      program_regs(9'd511, 32'd1);
      send_item(hufd_pkg::OP_START, '0, '0, 32'h0);
      send_item(hufd_pkg::OP_DATA,  '0, '0, 32'h0000_0000);
      wait_idle();
      program_regs(9'd511, 32'hFFFF_FFFF);
      send_item(hufd_pkg::OP_START, '0, '0, 32'h0);
      send_item(hufd_pkg::OP_DATA,  '0, '0, 32'hAAAA_AAAA);
   endtask

   // a leaf root repeats its byte at every bit position
   task automatic test_leaf_root();
      wait_idle();
      program_regs(9'h0A5, 32'd40);
      send_item(hufd_pkg::OP_START, '0, '0, 32'h0);
      send_item(hufd_pkg::OP_DATA,  '0, '0, $urandom);   // full run of copies
      send_item(hufd_pkg::OP_DATA,  '0, '0, $urandom);   // the last eight, then done
      wait_idle();
      program_regs(9'h000, 32'hFFFF_FFFF);
      send_item(hufd_pkg::OP_START, '0, '0, 32'h0);
      send_item(hufd_pkg::OP_DATA,  '0, '0, 32'h1234_5678);
   endtask

   // unused op code must leave state alone
   task automatic test_spare_op();
      send_item(OP_SPARE, '1, '1, 32'hFFFF_FFFF);
      send_item(OP_SPARE, '0, '0, 32'h0);
      send_item(hufd_pkg::OP_DATA,  '0, '0, 32'h0F0F_0F0F);
   endtask

   // ---------------------------------------------------------------
   // random streams: fresh tree, fresh settings, then coded words with noise
   // ---------------------------------------------------------------
   task automatic test_random_streams();
      logic [NODE_W-1:0] top;
      logic [NODE_W-1:0] root;
      logic [NODE_W-1:0] val;
      logic [SIZE_W-1:0] size;
      int                run_len;
      while (coded_items < RANDOM_ITEMS) begin
         build_tree(top);
         root = ($urandom_range(0, 9) < 8) ? top : NODE_W'($urandom_range(0, 255));
         case ($urandom_range(0, 9))
            0:       size = '0;
            1:       size = 32'hFFFF_FFFF;
            2:       size = 32'd1;
            default: size = $urandom_range(1, 120);
         endcase
         wait_idle();
         program_regs(root, size);
         send_item(hufd_pkg::OP_START, NODE_W'($urandom), NODE_W'($urandom), $urandom);
         coded_items++;
         run_len = $urandom_range(3, 14);
         repeat (run_len) begin
            case ($urandom_range(0, 19))
               0: send_item(OP_SPARE, NODE_W'($urandom), NODE_W'($urandom), $urandom);
               1: begin
                  // stray load anywhere; never let it point at an unfinished node
                  val = NODE_W'($urandom);
                  if (!node_ready(val))
                     val = {1'b0, val[7:0]};
                  send_item(hufd_pkg::OP_LOAD, NODE_W'($urandom), val, $urandom);
                  coded_items++;
               end
               2: begin
                  send_item(hufd_pkg::OP_START, NODE_W'($urandom), NODE_W'($urandom),
                            $urandom);
                  coded_items++;
               end
               3: begin
                  send_item(hufd_pkg::OP_DATA, NODE_W'($urandom), NODE_W'($urandom),
                            ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF);
                  coded_items++;
               end
               default: begin
                  send_item(hufd_pkg::OP_DATA, NODE_W'($urandom), NODE_W'($urandom),
                            $urandom);
                  coded_items++;
               end
            endcase
            if (coded_items >= (RANDOM_ITEMS * 4) / 5)
               quiet = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_tree_walk();
      test_size_extremes();
      test_leaf_root();
      test_spare_op();
      test_random_streams();
      wait_idle();
      if (expected_bytes.size() != 0)
         errors++;
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // generous bound on the slowest legal run
   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

### sim.f
rtl/core/hufd_pkg.sv
rtl/core/hufd_ram.sv
rtl/core/hufd_ctrl.sv
rtl/core/hufd_datapath.sv
rtl/core/huffman_tree_byte_decoder_unit.sv
bench/huffman_tree_byte_decoder_unit_test.sv
